### rtl/core/chtlp_pkg.sv
package chtlp_pkg;

    localparam int KEY_W = 63;
    localparam int CNT_W = 48;
    localparam int IDX_W = 10;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_READ     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_CLR,
        BK_IDLE,
        BK_HASH,
        BK_HMOD,
        BK_RD,
        BK_WAIT,
        BK_EVAL,
        BK_OUT
    } bk_state_t;

    // request handed from the front part to the back part
    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  amount;
        logic [IDX_W-1:0]  slot_index;
    } req_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

### rtl/core/chtlp_ram.sv
module chtlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/chtlp_front.sv
module chtlp_front
    import chtlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_req,
    output logic        q_valid,
    input  logic        q_ready,
    output req_t        q_req
);

    // two-entry queue between accept and the probing engine
    req_t        buf_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push)
        else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance");
`endif

endmodule

### rtl/core/chtlp_back.sv
module chtlp_back
    import chtlp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  req_t              q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        out_status,
    output logic [IDX_W-1:0]  out_slot,
    output logic              out_slot_valid,
    output logic [KEY_W-1:0]  out_slot_key,
    output logic [CNT_W-1:0]  out_slot_count,
    output logic [CNT_W-1:0]  out_total
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = AW + 1;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
    localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);
    localparam bit POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
    // reciprocal of the depth scaled by 2^(KEY_W+AW): the quotient is exact
    // for every key, and it fits in 64 bits
    localparam int RSH = KEY_W + AW;
    localparam logic [127:0] RECIP_W =
        ((128'd1 << RSH) + 128'(TABLE_DEPTH) - 128'd1) / 128'(TABLE_DEPTH);
    localparam logic [63:0] RECIP = RECIP_W[63:0];
    localparam logic [AW-1:0] DEPTH_LO = AW'(TABLE_DEPTH);

    bk_state_t state_reg, state_next;

    req_t              req_reg;
    logic [AW-1:0]     idx_reg, idx_next, home_reg, home_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [1:0]        st_reg, st_next;
    logic [IDX_W-1:0]  oslot_reg, oslot_next;
    logic              ovalid_reg, ovalid_next;
    logic [KEY_W-1:0]  okey_reg, okey_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic [AW-1:0]     clr_reg, clr_next;

    // home slot by reciprocal multiply, one 32x32 partial product a cycle
    logic [127:0]      acc_reg, acc_next;
    logic [1:0]        hstep_reg, hstep_next;
    logic [KEY_W-1:0]  hval;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [127:0]      mul_sh;
    logic [AW-1:0]     q_lo, qd, hrem;

    // occupancy flag rides in the top bit of the key memory
    logic              occ_hit;
    logic              kwe, cwe;
    logic [AW-1:0]     kwaddr;
    logic [KEY_W:0]    kwdata, krd_raw;
    logic [KEY_W-1:0]  krd;
    logic [CNT_W-1:0]  crd, cwdata, after;
    logic [AW-1:0]     home_idx;
    logic [AW-1:0]     rd_idx;

    // low bits give the slot when the depth is a power of two
    function automatic logic [AW-1:0] wrap_mod(input logic [KEY_W-1:0] v);
        return v[AW-1:0];
    endfunction

    assign home_idx = wrap_mod(q_req.key);
    assign rd_idx   = wrap_mod(KEY_W'(q_req.slot_index));

    chtlp_ram #(.WIDTH(KEY_W + 1), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata),
        .raddr(idx_reg), .rdata(krd_raw));

    chtlp_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
        .clk(clk), .we(cwe), .waddr(idx_reg), .wdata(cwdata),
        .raddr(idx_reg), .rdata(crd));

    assign krd     = krd_raw[KEY_W-1:0];
    assign occ_hit = krd_raw[KEY_W];
    assign after   = sat_add(crd, req_reg.amount);

    assign hval = req_reg.func ? KEY_W'(req_reg.slot_index) : req_reg.key;

    always_comb
    begin
        mul_a = hval[31:0];
        mul_b = RECIP[31:0];
        case (hstep_reg)
            2'd1:
            begin
                mul_b = RECIP[63:32];
            end
            2'd2:
            begin
                mul_a = {1'b0, hval[KEY_W-1:32]};
            end
            2'd3:
            begin
                mul_a = {1'b0, hval[KEY_W-1:32]};
                mul_b = RECIP[63:32];
            end
            default: ;
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb
    begin
        case (hstep_reg)
            2'd0:    mul_sh = {64'd0, mul_p};
            2'd3:    mul_sh = {mul_p, 64'd0};
            default: mul_sh = {32'd0, mul_p, 32'd0};
        endcase
    end

    // remainder fits in AW bits, so only the low bits of q * depth matter
    assign q_lo = acc_reg[RSH +: AW];
    assign qd   = q_lo * DEPTH_LO;
    assign hrem = hval[AW-1:0] - qd;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLR:  if (clr_reg == LAST) state_next = BK_IDLE;
            BK_IDLE: if (q_valid) state_next = POW2 ? BK_RD : BK_HASH;
            BK_HASH: if (hstep_reg == 2'd3) state_next = BK_HMOD;
            BK_HMOD: state_next = BK_RD;
            BK_RD:   state_next = BK_WAIT;
            BK_WAIT: state_next = BK_EVAL;
            BK_EVAL:
            begin
                if (req_reg.func || !occ_hit || krd == req_reg.key ||
                    n_reg + NW'(1) == DEPTH_N)
                begin
                    state_next = BK_OUT;
                end
                else
                begin
                    state_next = BK_RD;
                end
            end
            BK_OUT:  if (out_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready     = (state_reg == BK_IDLE);
        idx_next    = idx_reg;
        home_next   = home_reg;
        n_next      = n_reg;
        total_next  = total_reg;
        st_next     = st_reg;
        oslot_next  = oslot_reg;
        ovalid_next = ovalid_reg;
        okey_next   = okey_reg;
        ocnt_next   = ocnt_reg;
        clr_next    = clr_reg;
        acc_next    = acc_reg;
        hstep_next  = hstep_reg;
        kwe         = 1'b0;
        kwaddr      = idx_reg;
        kwdata      = {1'b1, req_reg.key};
        cwe         = 1'b0;
        cwdata      = req_reg.amount;
        case (state_reg)
            BK_CLR:
            begin
                kwe      = 1'b1;
                kwaddr   = clr_reg;
                kwdata   = '0;
                clr_next = clr_reg + AW'(1);
                n_next   = '0;
            end
            BK_IDLE:
            begin
                idx_next   = q_req.func ? rd_idx : home_idx;
                home_next  = home_idx;
                n_next     = '0;
                acc_next   = '0;
                hstep_next = '0;
            end
            BK_HASH:
            begin
                acc_next   = acc_reg + mul_sh;
                hstep_next = hstep_reg + 2'd1;
            end
            BK_HMOD:
            begin
                idx_next  = hrem;
                home_next = hrem;
            end
            BK_EVAL:
            begin
                oslot_next = IDX_W'(idx_reg);
                if (req_reg.func)
                begin
                    st_next     = ST_READ;
                    ovalid_next = occ_hit;
                    okey_next   = occ_hit ? krd : '0;
                    ocnt_next   = occ_hit ? crd : '0;
                end
                else if (!occ_hit)
                begin
                    st_next     = ST_INSERTED;
                    kwe         = 1'b1;
                    cwe         = 1'b1;
                    ovalid_next = 1'b1;
                    okey_next   = req_reg.key;
                    ocnt_next   = req_reg.amount;
                    total_next  = sat_add(total_reg, req_reg.amount);
                end
                else if (krd == req_reg.key)
                begin
                    st_next     = ST_UPDATED;
                    cwe         = 1'b1;
                    cwdata      = after;
                    ovalid_next = 1'b1;
                    okey_next   = krd;
                    ocnt_next   = after;
                    total_next  = sat_add(total_reg, after - crd);
                end
                else if (n_reg + NW'(1) == DEPTH_N)
                begin
                    st_next     = ST_FULL;
                    oslot_next  = IDX_W'(home_reg);
                    ovalid_next = 1'b0;
                    okey_next   = '0;
                    ocnt_next   = '0;
                end
                else
                begin
                    idx_next = (idx_reg == LAST) ? '0 : idx_reg + AW'(1);
                    n_next   = n_reg + NW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && q_valid)
        begin
            req_reg <= q_req;
        end
        home_reg  <= home_next;
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        acc_reg   <= acc_next;
        hstep_reg <= hstep_next;
        st_reg    <= st_next;
        oslot_reg <= oslot_next;
        ovalid_reg <= ovalid_next;
        okey_reg  <= okey_next;
        ocnt_reg  <= ocnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLR;
            total_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            clr_reg   <= clr_next;
        end
    end

    assign out_valid      = (state_reg == BK_OUT);
    assign out_status     = st_reg;
    assign out_slot       = oslot_reg;
    assign out_slot_valid = ovalid_reg;
    assign out_slot_key   = okey_reg;
    assign out_slot_count = ocnt_reg;
    assign out_total      = total_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_total))
        else $error("result dropped while stalled");
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg < DEPTH_N)
        else $error("probe count past depth");
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BK_EVAL |=> total_reg == $past(total_reg))
        else $error("total moved outside evaluation");
`endif

endmodule

### rtl/core/counting_hash_table_linear_probe_top.sv
// Channel | Group          | Fields (lowest bit first)
// in      | s_axis_*       | tdata: key[62:0] add_amount[110:63] slot_index[120:111]
//         |                | tuser: func
// out     | m_axis_*       | tdata: slot[9:0] slot_valid[10] slot_key[73:11]
//         |                |        slot_count[121:74] total_count[169:122]
//         |                | tuser: status[1:0]
// Each probe reads the key and count memories through their registered read
// port and evaluates once. A depth that is not a power of two adds hash steps
// to form the home slot. A read item or a hit at the home slot needs a single
// probe; a full table scans every slot. After reset the engine clears the
// occupancy flags in one pass over the table, the total at once. A two-entry
// request queue keeps accepting, until both entries hold requests, while the
// probing engine works, clears, or its result waits on m_axis_tready.
module counting_hash_table_linear_probe_top
    import chtlp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // key, add_amount, slot_index
    input  logic         s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata,   // slot, slot_valid, slot_key, slot_count, total_count
    output logic [1:0]   m_axis_tuser    // status
);

    req_t in_req, q_req;
    logic q_valid, q_ready;
    logic [IDX_W-1:0] o_slot;
    logic             o_valid;
    logic [KEY_W-1:0] o_key;
    logic [CNT_W-1:0] o_cnt, o_total;

    // unpack the request
    assign in_req.func       = s_axis_tuser;
    assign in_req.key        = s_axis_tdata[62:0];
    assign in_req.amount     = s_axis_tdata[110:63];
    assign in_req.slot_index = s_axis_tdata[120:111];

    chtlp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

    chtlp_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(m_axis_tuser), .out_slot(o_slot),
        .out_slot_valid(o_valid), .out_slot_key(o_key),
        .out_slot_count(o_cnt), .out_total(o_total));

    // pack the result, zero fill to whole bytes
    assign m_axis_tdata = {6'd0, o_total, o_cnt, o_key, o_valid, o_slot};

endmodule

### tb/sv/counting_hash_table_linear_probe_top_tb.sv
`timescale 1ns / 100ps

module counting_hash_table_linear_probe_top_tb
    import chtlp_pkg::*;
();

    localparam int DEPTH = 1024;

    // One result as it leaves the block
    typedef struct {
        status_t          status;
        logic [IDX_W-1:0] slot;
        logic             slot_valid;
        logic [KEY_W-1:0] slot_key;
        logic [CNT_W-1:0] slot_count;
        logic [CNT_W-1:0] total_count;
    } slot_result_t;

    // Mirror of the table: predicts every result from accepted requests and
    // checks the block's results against them in order.
    class hash_scoreboard;
        bit               occ[DEPTH];
        bit [KEY_W-1:0]   keys[DEPTH];
        bit [CNT_W-1:0]   counts[DEPTH];
        bit [CNT_W-1:0]   total;
        int               n_occ;
        slot_result_t     pending[$];
        int               errors;

        function bit [CNT_W-1:0] add_sat(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
            bit [CNT_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
        endfunction

        function slot_result_t slot_view(status_t st, int idx, bit show);
            slot_result_t r;
            r.status      = st;
            r.slot        = idx[IDX_W-1:0];
            r.slot_valid  = show && occ[idx];
            r.slot_key    = r.slot_valid ? keys[idx] : '0;
            r.slot_count  = r.slot_valid ? counts[idx] : '0;
            r.total_count = total;
            return r;
        endfunction

        function void note_request(bit func, bit [KEY_W-1:0] key,
                                   bit [CNT_W-1:0] amount, bit [IDX_W-1:0] index);
            int home;
            int idx;
            bit [CNT_W-1:0] was;
            if (func)
            begin
                pending.push_back(slot_view(ST_READ, int'(index) % DEPTH, 1'b1));
                return;
            end
            home = int'(key % DEPTH);
            idx = home;
            for (int n = 0; n < DEPTH; n++)
            begin
                if (occ[idx] && keys[idx] == key)
                begin
                    was = counts[idx];
                    counts[idx] = add_sat(was, amount);
                    total = add_sat(total, counts[idx] - was);
                    pending.push_back(slot_view(ST_UPDATED, idx, 1'b1));
                    return;
                end
                if (!occ[idx])
                begin
                    occ[idx] = 1'b1;
                    n_occ++;
                    keys[idx] = key;
                    counts[idx] = amount;
                    total = add_sat(total, amount);
                    pending.push_back(slot_view(ST_INSERTED, idx, 1'b1));
                    return;
                end
                idx = (idx + 1) % DEPTH;
            end
            pending.push_back(slot_view(ST_FULL, home, 1'b0));
        endfunction

        function void check_result(slot_result_t got);
            slot_result_t exp;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d slot %0d", got.status, got.slot);
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.slot !== exp.slot ||
                got.slot_valid !== exp.slot_valid || got.slot_key !== exp.slot_key ||
                got.slot_count !== exp.slot_count || got.total_count !== exp.total_count)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch exp: st %0d slot %0d v %0b key %h cnt %h tot %h",
                             exp.status, exp.slot, exp.slot_valid, exp.slot_key,
                             exp.slot_count, exp.total_count);
                    $display("         got: st %0d slot %0d v %0b key %h cnt %h tot %h",
                             got.status, got.slot, got.slot_valid, got.slot_key,
                             got.slot_count, got.total_count);
                end
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // key, add_amount, slot_index
    logic         s_axis_tuser = 1'b0; // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;        // slot, slot_valid, slot_key, slot_count, total_count
    logic [1:0]   m_axis_tuser;        // status

    hash_scoreboard sb = new();

    // Switch off idling on either side during steady stretches
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_stall = 0;

    bit [KEY_W-1:0] pool[32];

    always #2 clk = ~clk;

    counting_hash_table_linear_probe_top #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Mostly short gaps, now and then a long one
    function int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function bit [KEY_W-1:0] rand_key();
        return KEY_W'({$urandom(), $urandom()});
    endfunction

    function bit [CNT_W-1:0] rand_amount();
        return CNT_W'({$urandom(), $urandom()});
    endfunction

    // Check each accepted result, then pick the next ready value
    always @(posedge clk)
    begin
        slot_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status      = status_t'(m_axis_tuser);
            got.slot        = m_axis_tdata[9:0];
            got.slot_valid  = m_axis_tdata[10];
            got.slot_key    = m_axis_tdata[73:11];
            got.slot_count  = m_axis_tdata[121:74];
            got.total_count = m_axis_tdata[169:122];
            sb.check_result(got);
        end
        if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!rx_steady && $urandom_range(0, 99) < 25)
        begin
            rx_stall <= pick_gap(1'b0);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Present one request, hold it until accepted, then idle for a random gap, which may be none
    task automatic send_request(input bit func, input bit [KEY_W-1:0] key,
                                input bit [CNT_W-1:0] amount, input bit [IDX_W-1:0] index);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, index, amount, key};
        s_axis_tuser  <= func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(func, key, amount, index);
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_key(input bit [KEY_W-1:0] key, input bit [CNT_W-1:0] amount);
        send_request(1'b0, key, amount, IDX_W'(rand_key()));
    endtask

    task automatic read_slot(input bit [IDX_W-1:0] index);
        send_request(1'b1, rand_key(), rand_amount(), index);
    endtask

    initial
    begin
        bit [KEY_W-1:0] k;
        int i;
        bit [IDX_W-1:0] homes[16];

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty reads, zero amount insert, update, collisions, wrap
        read_slot(10'd0);
        read_slot(10'd1023);
        add_key('0, '0);
        add_key('0, 48'd5);
        add_key(63'd1024, 48'd7);
        add_key({KEY_W{1'b1}}, 48'd1);
        add_key(63'd1023, 48'd2);
        add_key(63'h5555_5555_5555_5555, 48'd3);
        add_key(63'h2AAA_AAAA_AAAA_AAAA, 48'd4);
        read_slot(10'd0);
        read_slot(10'd1);
        read_slot(10'd2);
        read_slot(10'd1023);
        read_slot(10'd500);
        read_slot(10'h155);
        read_slot(10'h2AA);

        // Random: a small pool of keys crowded onto few home slots
        for (i = 0; i < 16; i++)
            homes[i] = IDX_W'($urandom_range(0, DEPTH - 1));
        for (i = 0; i < 32; i++)
        begin
            pool[i] = rand_key();
            pool[i][IDX_W-1:0] = homes[i % 16];
        end
        for (i = 0; i < 250; i++)
        begin
            if (i % 80 == 0)
            begin
                tx_steady = $urandom_range(0, 2) == 0;
                rx_steady = $urandom_range(0, 2) == 0;
            end
            case ($urandom_range(0, 19))
                0, 1, 2:        add_key(rand_key(), CNT_W'($urandom_range(0, 1000)));
                3, 4, 5, 6, 7:  read_slot(IDX_W'($urandom_range(0, DEPTH - 1)));
                default:        add_key(pool[$urandom_range(0, 31)],
                                        CNT_W'($urandom_range(0, 1000)));
            endcase
        end

        // Fill every remaining slot; displaced keys probe past clusters
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        i = 0;
        while (sb.n_occ < DEPTH)
        begin
            k = rand_key();
            k[IDX_W-1:0] = i[IDX_W-1:0];
            add_key(k, CNT_W'($urandom_range(0, 50)));
            i++;
        end

        // Full table: new keys drop, existing keys update, then saturation
        add_key(rand_key(), 48'd9);
        add_key('0, 48'd1);
        for (i = 0; i < 90; i++)
        begin
            case ($urandom_range(0, 9))
                0:          add_key(pool[$urandom_range(0, 31)], rand_amount());
                1, 2, 3:    read_slot(IDX_W'($urandom_range(0, DEPTH - 1)));
                default:    add_key(pool[$urandom_range(0, 31)],
                                    CNT_W'($urandom_range(0, 1000)));
            endcase
            if (i == 45)
                add_key(rand_key(), rand_amount());
        end
        add_key(pool[0], {CNT_W{1'b1}});
        add_key(pool[0], {CNT_W{1'b1}});
        add_key(pool[1], 48'h5555_5555_5555);
        add_key(pool[1], 48'hAAAA_AAAA_AAAA);
        add_key(rand_key(), {CNT_W{1'b1}});
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
